[src/chs_pkg.sv]
package chs_pkg;

  // Field widths of the request and response beats.
  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // Operation codes; code three behaves as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_KEY  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              hash_step;
    logic              hash_final;
    logic              mod_step;
    logic              seed;
    logic              clr_step;
    logic              wr_entry;
    logic              wr_link;
    logic              wr_new;
    logic              follow;
    logic              set_result;
    logic [STAT_W-1:0] res_status;
    logic              res_take_found;
    logic              out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;
    logic is_insert;
    logic is_remove;
    logic cnt3;
    logic clr_last;
    logic hit;
    logic empty;
    logic link_none;
    logic cellar_full;
    logic out_busy;
  } sts_t;

endpackage

[src/chs_req_if.sv]
interface chs_req_if;
  import chs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] lookup_key;
  logic [VAL_W-1:0] store_value;

  modport source (output valid, output operation, output lookup_key, output store_value,
                  input ready);
  modport sink (input valid, input operation, input lookup_key, input store_value,
                output ready);
endinterface

[src/chs_rsp_if.sv]
interface chs_rsp_if;
  import chs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink (input valid, input status, input found_value, output ready);
endinterface

[src/coalesced_hash_table_top.sv]
// Channel  Direction  Beat fields
// req      in         operation, lookup_key, store_value
// rsp      out        status, found_value
//
// A request is taken only once the previous one has left the controller: it runs the
// byte-serial hash, the reciprocal-multiply remainder and a walk of 1 to CELLAR_SLOTS + 1
// chain slots through the single port of the slot store, plus an append when a cellar
// slot is added; a zero key skips the hash and the walk.
// After reset a clearing sweep over all HOME_SLOTS + CELLAR_SLOTS slots runs with
// req.ready low. A response waits in the output register while rsp stalls; the
// next request is taken meanwhile and finishes once that register is free.
module coalesced_hash_table_top #(
  parameter int HOME_SLOTS   = 128,
  parameter int CELLAR_SLOTS = 16
) (
  input logic       clk,
  input logic       rst,
  chs_req_if.sink   req,
  chs_rsp_if.source rsp
);
  import chs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chs_dpath #(
    .HOME_SLOTS  (HOME_SLOTS),
    .CELLAR_SLOTS(CELLAR_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .operation  (req.operation),
    .lookup_key (req.lookup_key),
    .store_value(req.store_value),
    .cmd        (cmd),
    .sts        (sts),
    .rsp        (rsp)
  );

endmodule

[src/chs_ram.sv]
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write when enabled, registered read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/chs_ctrl.sv]
module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  chs_pkg::sts_t sts,
  output chs_pkg::cmd_t cmd
);
  import chs_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_HASH   = 4'd3;
  localparam logic [3:0] S_FINAL  = 4'd4;
  localparam logic [3:0] S_MOD    = 4'd5;
  localparam logic [3:0] S_SEED   = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_CHECK  = 4'd8;
  localparam logic [3:0] S_APPEND = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  // State register; reset starts the clearing sweep of the slot store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.key_zero) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ST_ZERO_KEY;
          state_next     = S_DONE;
        end else begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.cnt3) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.hash_final = 1'b1;
        state_next     = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        state_next   = S_SEED;
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.is_insert) begin
          if (sts.empty) begin
            cmd.wr_entry   = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_status = ST_OK;
            state_next     = S_DONE;
          end else if (sts.link_none) begin
            if (sts.cellar_full) begin
              cmd.set_result = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_DONE;
            end else begin
              cmd.wr_link = 1'b1;
              state_next  = S_APPEND;
            end
          end else begin
            cmd.follow = 1'b1;
            state_next = S_READ;
          end
        end else begin
          if (sts.hit) begin
            cmd.wr_entry       = sts.is_remove;
            cmd.set_result     = 1'b1;
            cmd.res_status     = ST_OK;
            cmd.res_take_found = 1'b1;
            state_next         = S_DONE;
          end else if (sts.link_none) begin
            cmd.set_result = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_DONE;
          end else begin
            cmd.follow = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_APPEND: begin
        cmd.wr_new     = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/chs_dpath.sv]
module chs_dpath #(
  parameter int HOME_SLOTS   = 128,
  parameter int CELLAR_SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [chs_pkg::OP_W-1:0]  operation,
  input  logic [chs_pkg::KEY_W-1:0] lookup_key,
  input  logic [chs_pkg::VAL_W-1:0] store_value,
  input  chs_pkg::cmd_t             cmd,
  output chs_pkg::sts_t             sts,
  chs_rsp_if.source                 rsp
);
  import chs_pkg::*;

  localparam int TOTAL  = HOME_SLOTS + CELLAR_SLOTS;
  localparam int SLOT_W = $clog2(TOTAL);
  localparam int CU_W   = $clog2(CELLAR_SLOTS + 1);
  localparam int RW     = $clog2(HOME_SLOTS) + 1;
  localparam int EW     = KEY_W + VAL_W + SLOT_W;
  localparam logic [RW-1:0]     HOME_N   = RW'(HOME_SLOTS);
  localparam logic [SLOT_W-1:0] HOME_IDX = SLOT_W'(HOME_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TOTAL - 1);
  localparam logic [31:0]       RECIP    = 32'((64'd1 << 32) / 64'(HOME_SLOTS));

  // Request registers.
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [KEY_W-1:0]  byte_sh;
  logic [31:0]       hash_q;
  logic [31:0]       hash_step_v;
  logic [31:0]       hash_final_v;
  logic [2:0]        cnt;

  // Remainder by the home size.
  logic [63:0]       prod;
  logic [31:0]       quo_q;
  logic [RW-1:0]     rem_raw;
  logic [RW-1:0]     rem;

  // Chain walk state.
  logic [SLOT_W-1:0] slot;
  logic [CU_W-1:0]   cellar_used;
  logic [SLOT_W-1:0] new_idx;

  // Store port.
  logic              we;
  logic [EW-1:0]     wdata;
  logic [EW-1:0]     rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic [SLOT_W-1:0] rd_link;

  // Result registers.
  logic [STAT_W-1:0] status_q;
  logic [VAL_W-1:0]  found_q;

  assign rd_key  = rdata[EW-1 -: KEY_W];
  assign rd_val  = rdata[SLOT_W +: VAL_W];
  assign rd_link = rdata[SLOT_W-1:0];
  assign new_idx = HOME_IDX + SLOT_W'(cellar_used);

  // One byte of the one-at-a-time mix, the byte taken as a signed char.
  always_comb begin
    logic [31:0] h1;
    logic [31:0] h2;
    h1          = hash_q + {{24{byte_sh[7]}}, byte_sh[7:0]};
    h2          = h1 + (h1 << 10);
    hash_step_v = h2 ^ (h2 >> 6);
  end

  // Closing avalanche of the hash.
  always_comb begin
    logic [31:0] f1;
    logic [31:0] f2;
    f1           = hash_q + (hash_q << 3);
    f2           = f1 ^ (f1 >> 11);
    hash_final_v = f2 + (f2 << 15);
  end

  // The reciprocal estimate of the quotient is exact or one short, so the low
  // bits of hash minus estimate times home size need at most one subtraction.
  assign prod    = 64'(hash_q) * 64'(RECIP);
  assign rem_raw = hash_q[RW-1:0] - quo_q[RW-1:0] * HOME_N;
  assign rem     = (rem_raw >= HOME_N) ? rem_raw - HOME_N : rem_raw;

  // Request capture, hashing and quotient estimate.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      key_q   <= lookup_key;
      val_q   <= store_value;
      byte_sh <= lookup_key;
      hash_q  <= '0;
      cnt     <= '0;
    end else if (cmd.hash_step) begin
      hash_q  <= hash_step_v;
      byte_sh <= byte_sh >> 8;
      cnt     <= cnt + 3'd1;
    end else if (cmd.hash_final) begin
      hash_q <= hash_final_v;
      cnt    <= '0;
    end else if (cmd.mod_step) begin
      quo_q <= prod[63:32];
    end
  end

  // Slot pointer doubles as the clearing counter; cellar allocation count.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= '0;
      cellar_used <= '0;
    end else begin
      if (cmd.clr_step) begin
        slot <= slot + SLOT_W'(1);
      end else if (cmd.seed) begin
        slot <= SLOT_W'(rem);
      end else if (cmd.follow) begin
        slot <= rd_link;
      end else if (cmd.wr_link) begin
        slot        <= new_idx;
        cellar_used <= cellar_used + CU_W'(1);
      end
    end
  end

  // Write data for the slot store.
  always_comb begin
    we    = cmd.clr_step | cmd.wr_entry | cmd.wr_link | cmd.wr_new;
    wdata = '0;
    if (cmd.wr_entry) begin
      if (op_q == OP_INSERT) begin
        wdata = {key_q, val_q, rd_link};
      end else begin
        wdata = {{KEY_W{1'b0}}, {VAL_W{1'b0}}, rd_link};
      end
    end else if (cmd.wr_link) begin
      wdata = {rd_key, rd_val, new_idx};
    end else if (cmd.wr_new) begin
      wdata = {key_q, val_q, {SLOT_W{1'b0}}};
    end
  end

  chs_ram #(
    .WIDTH(EW),
    .DEPTH(TOTAL)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .addr (slot),
    .wdata(wdata),
    .rdata(rdata)
  );

  // Result capture.
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      status_q <= cmd.res_status;
      found_q  <= cmd.res_take_found ? rd_val : '0;
    end
  end

  // Output register; holds the beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status      <= status_q;
      rsp.found_value <= found_q;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.key_zero    = (key_q == '0);
    sts.is_insert   = (op_q == OP_INSERT);
    sts.is_remove   = (op_q == OP_REMOVE);
    sts.cnt3        = (cnt == 3'd3);
    sts.clr_last    = (slot == LAST_IDX);
    sts.hit         = (rd_key == key_q);
    sts.empty       = (rd_key == '0);
    sts.link_none   = (rd_link == '0);
    sts.cellar_full = (cellar_used == CU_W'(CELLAR_SLOTS));
    sts.out_busy    = rsp.valid & ~rsp.ready;
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import chs_pkg::*;

  localparam int unsigned HOME   = 128;
  localparam int unsigned CELLAR = 16;
  localparam int unsigned TOTAL  = HOME + CELLAR;

  // Code three is not named by the package; the block treats it as a lookup.
  localparam logic [OP_W-1:0] OP_ALIAS_LOOKUP = 2'd3;

  localparam int RANDOM_ITEMS = 827;
  localparam int CALM_FROM    = 400;
  localparam int CALM_UPTO    = 550;
  localparam int STALL_AT     = 200;
  localparam int STALL_LEN    = 300;
  localparam int SETTLE       = 60;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int BIG_GROUP    = 18;
  localparam int SMALL_GROUP  = 4;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               drain_first;
  } request_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
  } reply_t;

  logic clk = 1'b0;
  logic rst;

  chs_req_if req_ch ();
  chs_rsp_if rsp_ch ();

  coalesced_hash_table_top #(
    .HOME_SLOTS  (HOME),
    .CELLAR_SLOTS(CELLAR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the slot store.
  logic [KEY_W-1:0] slot_key  [TOTAL];
  logic [VAL_W-1:0] slot_val  [TOTAL];
  int unsigned      slot_link [TOTAL];
  int unsigned      cellar_taken;

  request_t request_backlog[$];
  reply_t   owed_replies[$];

  int accepted_count    = 0;
  int mismatches        = 0;
  int cycle_count       = 0;
  int stall_cycles_left = 0;
  bit stall_fired       = 1'b0;
  int total_requests;

  // Keys grouped so that each group shares one home slot.
  logic [KEY_W-1:0] chain_keys [5][BIG_GROUP];
  logic [KEY_W-1:0] edge_keys  [6] = '{32'hFFFF_FFFF, 32'h8080_8080, 32'h7F7F_7F7F,
                                       32'h0000_0001, 32'h8000_0000, 32'h0000_00FF};

  // One-at-a-time hash over the four key bytes, each sign-extended first.
  function automatic logic [31:0] oat_hash(input logic [KEY_W-1:0] key);
    logic [31:0] h;
    logic [31:0] b;
    h = '0;
    for (int n = 0; n < 4; n++) begin
      b = {{24{key[8*n+7]}}, key[8*n +: 8]};
      h += b;
      h += h << 10;
      h ^= h >> 6;
    end
    h += h << 3;
    h ^= h >> 11;
    h += h << 15;
    return h;
  endfunction

  function automatic int unsigned home_of(input logic [KEY_W-1:0] key);
    return oat_hash(key) % HOME;
  endfunction

  // Walks the chain from the home slot; TOTAL means the key is absent.
  function automatic int unsigned chain_locate(input logic [KEY_W-1:0] key);
    int unsigned s;
    s = home_of(key);
    for (int unsigned g = 0; g <= CELLAR; g++) begin
      if (slot_key[s] == key) return s;
      s = slot_link[s];
      if (s == 0) break;
    end
    return TOTAL;
  endfunction

  // Fills the first empty slot on the chain, or appends a cellar slot, or reports full.
  function automatic logic [STAT_W-1:0] chain_store(input logic [KEY_W-1:0] key,
                                                     input logic [VAL_W-1:0] val);
    int unsigned s;
    int unsigned nxt;
    s = home_of(key);
    for (int unsigned g = 0; g <= CELLAR; g++) begin
      if (slot_key[s] == '0) begin
        slot_key[s] = key;
        slot_val[s] = val;
        return ST_OK;
      end
      nxt = slot_link[s];
      if (nxt == 0) break;
      s = nxt;
    end
    if (cellar_taken >= CELLAR) return ST_FULL;
    nxt = HOME + cellar_taken;
    cellar_taken++;
    slot_link[s]   = nxt;
    slot_key[nxt]  = key;
    slot_val[nxt]  = val;
    slot_link[nxt] = 0;
    return ST_OK;
  endfunction

  // Applies one request to the shadow store and returns the reply it owes.
  function automatic reply_t hash_table_apply(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] val);
    reply_t      r;
    int unsigned s;
    r.key    = key;
    r.status = ST_NOT_FOUND;
    r.value  = '0;
    if (key == '0) begin
      r.status = ST_ZERO_KEY;
    end else if (op == OP_INSERT) begin
      r.status = chain_store(key, val);
    end else begin
      s = chain_locate(key);
      if (s < TOTAL) begin
        r.status = ST_OK;
        r.value  = slot_val[s];
        if (op == OP_REMOVE) begin
          slot_key[s] = '0;
          slot_val[s] = '0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_for_home(input int unsigned home);
    logic [KEY_W-1:0] k;
    do k = $urandom(); while (k == '0 || home_of(k) != home);
    return k;
  endfunction

  function automatic bit take_break();
    if (accepted_count >= CALM_FROM && accepted_count < CALM_UPTO) return 1'b0;
    return $urandom_range(99) < 30;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    int r;
    r = $urandom_range(99);
    if (r < 40) return chain_keys[0][$urandom_range(BIG_GROUP-1)];
    if (r < 70) return chain_keys[$urandom_range(4, 1)][$urandom_range(SMALL_GROUP-1)];
    if (r < 80) return edge_keys[$urandom_range(5)];
    if (r < 95) return $urandom();
    return '0;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val, input bit drain_first);
    request_t q;
    q.op          = op;
    q.key         = key;
    q.val         = val;
    q.drain_first = drain_first;
    request_backlog.push_back(q);
  endtask

  // Request driver: holds a beat until it is taken, then offers the next.
  always @(posedge clk) begin
    request_t nxt_req;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        owed_replies.push_back(hash_table_apply(req_ch.operation, req_ch.lookup_key,
                                                req_ch.store_value));
        accepted_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_backlog.size() != 0 && !take_break() &&
            !(request_backlog[0].drain_first &&
              (owed_replies.size() != 0 || req_ch.valid))) begin
          nxt_req = request_backlog.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.operation   <= nxt_req.op;
          req_ch.lookup_key  <= nxt_req.key;
          req_ch.store_value <= nxt_req.val;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the response side, counted down here.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles_left <= 0;
      stall_fired       <= 1'b0;
    end else if (!stall_fired && accepted_count >= STALL_AT) begin
      stall_cycles_left <= STALL_LEN;
      stall_fired       <= 1'b1;
    end else if (stall_cycles_left != 0) begin
      stall_cycles_left <= stall_cycles_left - 1;
    end
  end

  // Response monitor: checks each beat against the oldest owed reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected reply status %0d value %h", $realtime,
                     rsp_ch.status, rsp_ch.found_value);
        end else begin
          want = owed_replies.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.found_value !== want.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: key %h expected status %0d value %h, got status %0d value %h",
                       $realtime, want.key, want.status, want.value, rsp_ch.status,
                       rsp_ch.found_value);
          end
        end
      end
      rsp_ch.ready <= (stall_cycles_left == 0) && !take_break();
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned homes [5];
    logic [KEY_W-1:0] c0, c1, c2, c3;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_LOOKUP;
    req_ch.lookup_key  = '0;
    req_ch.store_value = '0;
    rsp_ch.ready       = 1'b0;

    for (int unsigned s = 0; s < TOTAL; s++) begin
      slot_key[s]  = '0;
      slot_val[s]  = '0;
      slot_link[s] = 0;
    end
    cellar_taken = 0;

    // Colliding key groups on distinct home slots.
    for (int g = 0; g < 5; g++) begin
      homes[g] = g * 25 + $urandom_range(24);
      for (int i = 0; i < BIG_GROUP; i++) chain_keys[g][i] = key_for_home(homes[g]);
    end
    c0 = chain_keys[0][0];
    c1 = chain_keys[0][1];
    c2 = chain_keys[0][2];
    c3 = chain_keys[0][3];

    // Extreme keys and values, zero keys under every code.
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, '1, 1'b0);
    queue_request(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
    queue_request(OP_INSERT, 32'h8080_8080, '0, 1'b0);
    queue_request(OP_LOOKUP, 32'h8080_8080, '1, 1'b0);
    queue_request(OP_LOOKUP, '0, '1, 1'b0);
    queue_request(OP_INSERT, '0, '1, 1'b0);
    queue_request(OP_REMOVE, '0, '1, 1'b0);
    queue_request(OP_ALIAS_LOOKUP, '0, '0, 1'b0);

    // A short chain: removal in the middle keeps the link, insert reuses the hole.
    queue_request(OP_INSERT, c0, 32'h1111_1111, 1'b0);
    queue_request(OP_INSERT, c1, 32'h2222_2222, 1'b0);
    queue_request(OP_INSERT, c2, 32'h3333_3333, 1'b0);
    queue_request(OP_LOOKUP, c2, '0, 1'b0);
    queue_request(OP_REMOVE, c1, '0, 1'b0);
    queue_request(OP_LOOKUP, c1, '0, 1'b0);
    queue_request(OP_REMOVE, c1, '0, 1'b0);
    queue_request(OP_INSERT, c3, 32'h4444_4444, 1'b0);
    queue_request(OP_LOOKUP, c2, '0, 1'b0);
    queue_request(OP_ALIAS_LOOKUP, c3, '0, 1'b0);

    // Duplicate insert: the first copy on the chain shadows the second.
    queue_request(OP_INSERT, c0, 32'h5555_5555, 1'b0);
    queue_request(OP_LOOKUP, c0, '0, 1'b0);
    queue_request(OP_REMOVE, c0, '0, 1'b0);
    queue_request(OP_LOOKUP, c0, '0, 1'b0);

    // Random mix; the cellar fills up along the way and later appends report full.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      int r;
      logic [OP_W-1:0] op;
      r = $urandom_range(99);
      if (r < 35) op = OP_LOOKUP;
      else if (r < 70) op = OP_INSERT;
      else if (r < 95) op = OP_REMOVE;
      else op = OP_ALIAS_LOOKUP;
      queue_request(op, random_key(), random_value(), i == 0 || i == 600);
    end
    total_requests = request_backlog.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests || owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
